>>> hw/rtl/dtps_pkg.sv
// Shared types and constants for the depth-tested pixel store.
package dtps_pkg;
  localparam int MaxWidth = 8;
  localparam int MaxHeight = 8;
  localparam int Pixels = MaxWidth * MaxHeight;
  localparam int IdxW = $clog2(Pixels);
  localparam int XW = $clog2(MaxWidth) > 0 ? $clog2(MaxWidth) : 1;
  localparam int YW = $clog2(MaxHeight) > 0 ? $clog2(MaxHeight) : 1;
  localparam int CntW = IdxW + 1;

  localparam logic [2:0] OP_SET = 3'd0;
  localparam logic [2:0] OP_FLUSH_ALL = 3'd1;
  localparam logic [2:0] OP_FLUSH_OUT = 3'd2;
  localparam logic [2:0] OP_FLUSH_IN = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd4;
  localparam logic [2:0] OP_CLEAR_PT = 3'd5;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FORMAT = 3'd2;
  localparam logic [2:0] REG_COL_OFS = 3'd3;
  localparam logic [2:0] REG_ROW_OFS = 3'd4;
  localparam logic [2:0] REG_BPR = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic set_read;    // issue depth read of item pixel
    logic set_write;   // finish set using read data
    logic clr_point;   // black the item pixel
    logic walk_read;   // read list entry at walk index, advance index
    logic walk_eval;   // read color store for the fetched entry
    logic walk_emit;   // compute result for the fetched entry
    logic walk_reset;  // restart walk index
    logic clr_all_step;// black the fetched entry, drop its mark
    logic clr_done;    // empty the list
    logic out_load;    // load output register with the final result
  } dtps_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_range;
    logic       walk_more;  // walk index below count
    logic       keep;       // fetched entry is kept by the current flush
    logic       kept_any;
  } dtps_sts_t;
endpackage

>>> hw/rtl/dtps_ctrl.sv
// Controller state machine for the depth-tested pixel store.
module dtps_ctrl import dtps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dtps_sts_t sts,
  output dtps_cmd_t cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_SETW  = 9'b000000100,
    S_WRD   = 9'b000001000,
    S_WEVAL = 9'b000010000,
    S_WEMIT = 9'b000100000,
    S_OUT   = 9'b001000000,
    S_CRD   = 9'b010000000,
    S_CEVAL = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.walk_reset = 1'b1;
        case (sts.op)
          OP_SET: begin
            if (sts.in_range) begin
              cmd.set_read = 1'b1;
              state_nxt = S_SETW;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          OP_CLEAR_PT: begin
            cmd.clr_point = sts.in_range;
            state_nxt = S_IDLE;
          end
          OP_FLUSH_ALL, OP_FLUSH_OUT, OP_FLUSH_IN: state_nxt = S_WRD;
          OP_CLEAR_ALL: state_nxt = S_CRD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SETW: begin
        cmd.set_write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WRD: begin
        if (sts.walk_more) begin
          cmd.walk_read = 1'b1;
          state_nxt = S_WEVAL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WEVAL: begin
        cmd.walk_eval = 1'b1;
        state_nxt = S_WEMIT;
      end
      S_WEMIT: begin
        // A kept entry pushes the held one out, so it waits for a free register.
        if (!sts.keep) begin
          state_nxt = S_WRD;
        end else if (!sts.kept_any || !ov_r || out_ready) begin
          cmd.walk_emit = 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_OUT: begin
        // The final result waits here for the output register.
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CRD: begin
        if (sts.walk_more) begin
          cmd.walk_read = 1'b1;
          state_nxt = S_CEVAL;
        end else begin
          cmd.clr_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CEVAL: begin
        cmd.clr_all_step = 1'b1;
        state_nxt = S_CRD;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.walk_emit && sts.kept_any) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

>>> hw/rtl/dtps_dp.sv
// Datapath: pixel stores, touched list, rectangle test and result formatting.
module dtps_dp import dtps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dtps_cmd_t   cmd,
  output dtps_sts_t   sts,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [31:0] in_depth,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [15:0] in_rect_left,
  input  logic [15:0] in_rect_top,
  input  logic [15:0] in_rect_right,
  input  logic [15:0] in_rect_bottom,
  input  logic [3:0]  width_in_use,
  input  logic [3:0]  height_in_use,
  input  logic        pixel_format,
  input  logic [15:0] column_offset,
  input  logic [15:0] row_offset,
  input  logic [15:0] bytes_per_row,
  output logic        out_write_enable,
  output logic [31:0] out_byte_address,
  output logic [31:0] out_write_data,
  output logic        out_four_bytes,
  output logic        out_last
);
  logic [31:0] depth_mem [Pixels];
  logic [31:0] color_mem [Pixels];
  logic [IdxW-1:0] list_mem [Pixels];
  logic [Pixels-1:0] visited_r, listed_r, written_r;
  logic [CntW-1:0] count_r, walk_r;

  logic [2:0]  op_r;
  logic signed [15:0] x_r, y_r, rl_r, rt_r, rr_r, rb_r;
  logic [31:0] z_r, col_r;

  logic [31:0] rd_depth_r, rd_color_r;
  logic [IdxW-1:0] ent_r;
  logic        pend_ok_r, kept_r;

  logic [31:0] pend_addr_r, prod_r;
  logic [31:0] held_addr_r, held_data_r;
  logic        held_fb_r;

  logic [31:0] oa_r, od_r;
  logic        owe_r, ofb_r, olast_r;

  logic [3:0] wlim, hlim;
  logic       in_range;
  logic [IdxW-1:0] pix;
  logic [XW-1:0] ex;
  logic [YW-1:0] ey;
  logic signed [15:0] exs, eys;
  logic in_rect;
  logic set_wins;
  logic [31:0] cur_depth, cur_color;
  logic [31:0] fmt_data;

  assign wlim = (width_in_use < 4'(MaxWidth)) ? width_in_use : 4'(MaxWidth);
  assign hlim = (height_in_use < 4'(MaxHeight)) ? height_in_use : 4'(MaxHeight);
  assign in_range = !x_r[15] && !y_r[15] && (x_r < 16'(wlim)) && (y_r < 16'(hlim));
  assign pix = IdxW'(y_r) * IdxW'(MaxWidth) + IdxW'(x_r);

  assign ex = XW'(ent_r % MaxWidth);
  assign ey = YW'(ent_r / MaxWidth);
  assign exs = 16'(ex);
  assign eys = 16'(ey);
  assign in_rect = (rl_r <= exs) && (exs <= rr_r) && (rt_r <= eys) && (eys <= rb_r);

  assign cur_depth = written_r[pix] ? rd_depth_r : 32'd0;
  assign cur_color = written_r[ent_r] ? rd_color_r : 32'd0;
  // Signed depth compare done as unsigned with the sign bits flipped.
  assign set_wins = !visited_r[pix] ||
                    ((z_r ^ 32'h8000_0000) < (cur_depth ^ 32'h8000_0000));

  assign fmt_data = pixel_format
    ? {16'd0, cur_color[23:19], cur_color[15:10], cur_color[7:3]}
    : cur_color;

  assign sts.op = op_r;
  assign sts.in_range = in_range;
  assign sts.walk_more = walk_r < count_r;
  assign sts.keep = pend_ok_r;
  assign sts.kept_any = kept_r;

  // Stores: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (cmd.set_read) begin
      rd_depth_r <= depth_mem[pix];
    end
    if (cmd.walk_eval) begin
      rd_color_r <= color_mem[ent_r];
    end
    if (cmd.walk_read) begin
      ent_r <= list_mem[walk_r[IdxW-1:0]];
    end
    if (cmd.set_write && set_wins) begin
      depth_mem[pix] <= z_r;
      color_mem[pix] <= col_r;
    end
    if (cmd.set_write && !visited_r[pix] && !listed_r[pix] &&
        count_r < CntW'(Pixels)) begin
      list_mem[count_r[IdxW-1:0]] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      listed_r <= '0;
      written_r <= '0;
      count_r <= '0;
      walk_r <= '0;
      kept_r <= 1'b0;
      pend_ok_r <= 1'b0;
    end else begin
      if (cmd.walk_reset) begin
        walk_r <= '0;
        kept_r <= 1'b0;
      end
      if (cmd.walk_read) walk_r <= walk_r + 1'b1;
      if (cmd.set_write) begin
        if (set_wins) begin
          written_r[pix] <= 1'b1;
        end
        if (!visited_r[pix]) begin
          visited_r[pix] <= 1'b1;
          if (!listed_r[pix] && count_r < CntW'(Pixels)) begin
            listed_r[pix] <= 1'b1;
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (cmd.clr_point) begin
        written_r[pix] <= 1'b0;
        visited_r[pix] <= 1'b0;
      end
      if (cmd.clr_all_step) begin
        written_r[ent_r] <= 1'b0;
        visited_r[ent_r] <= 1'b0;
        listed_r[ent_r] <= 1'b0;
      end
      if (cmd.clr_done) count_r <= '0;
      if (cmd.walk_eval) begin
        pend_ok_r <= (op_r == OP_FLUSH_ALL) || ((op_r == OP_FLUSH_OUT) && !in_rect) ||
                     ((op_r == OP_FLUSH_IN) && in_rect);
      end
      if (cmd.walk_emit) kept_r <= 1'b1;
    end
  end

  // Item and address pieces; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      x_r <= in_pos_x;
      y_r <= in_pos_y;
      z_r <= in_depth;
      col_r <= {in_alpha, in_red, in_green, in_blue};
      rl_r <= in_rect_left;
      rt_r <= in_rect_top;
      rr_r <= in_rect_right;
      rb_r <= in_rect_bottom;
    end
    if (cmd.walk_eval) begin
      prod_r <= (32'(ey) + 32'(row_offset)) * 32'(bytes_per_row);
      pend_addr_r <= (32'(ex) + 32'(column_offset)) << (pixel_format ? 1 : 2);
    end
  end

  // A kept result is held until the next kept entry or the end of the walk
  // tells whether it is the final one.
  always_ff @(posedge clk) begin
    if (cmd.walk_emit) begin
      held_addr_r <= pend_addr_r + prod_r;
      held_data_r <= fmt_data;
      held_fb_r <= !pixel_format;
    end
    if (cmd.out_load || (cmd.walk_emit && kept_r)) begin
      owe_r <= kept_r;
      oa_r <= kept_r ? held_addr_r : 32'd0;
      od_r <= kept_r ? held_data_r : 32'd0;
      ofb_r <= kept_r && held_fb_r;
      olast_r <= cmd.out_load;
    end
  end

  assign out_write_enable = owe_r;
  assign out_byte_address = oa_r;
  assign out_write_data = od_r;
  assign out_four_bytes = ofb_r;
  assign out_last = olast_r;
endmodule

>>> hw/rtl/depth_tested_pixel_store_flush.sv
// Top level of the depth-tested pixel store with touched-list flush.
// Usage:
//   The input channel takes one command per transfer: set, flush (all,
//   outside or inside a rectangle), clear all or clear point. in_ready is
//   high only while the controller is idle, so one command runs at a time.
//   A set runs through accept, decode with depth read and conditional
//   write; clear point, an out-of-range set and unused opcodes end after
//   decode. Clear all and a flush each walk the listed pixels in list
//   order; a flush may also wait on the output register.
//   Each kept pixel of a flush gives one transfer on the output channel;
//   a kept result is held until the next kept pixel or the end of the walk
//   shows whether it is the final one, which carries last. A flush that
//   keeps nothing gives one transfer with write enable low and last high.
//   Results leave from an output register; when the receiver stalls, the
//   walk pauses on the next kept entry until the register is free.
//   The APB port writes and reads six registers at byte addresses 4*i.
//   Reset clears the touched list, all valid and mark bits and the
//   registers to their defaults; stores read as black until written.
module depth_tested_pixel_store_flush import dtps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [31:0] in_depth,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [15:0] in_rect_left,
  input  logic [15:0] in_rect_top,
  input  logic [15:0] in_rect_right,
  input  logic [15:0] in_rect_bottom,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [31:0] out_byte_address,
  output logic [31:0] out_write_data,
  output logic        out_four_bytes,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [3:0]  width_r, height_r;
  logic        format_r;
  logic [15:0] colofs_r, rowofs_r, bpr_r;
  logic [2:0]  reg_sel;
  dtps_cmd_t   cmd;
  dtps_sts_t   sts;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 4'd8;
      height_r <= 4'd8;
      format_r <= 1'b0;
      colofs_r <= '0;
      rowofs_r <= '0;
      bpr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        REG_WIDTH:   width_r <= cfg_pwdata[3:0];
        REG_HEIGHT:  height_r <= cfg_pwdata[3:0];
        REG_FORMAT:  format_r <= cfg_pwdata[0];
        REG_COL_OFS: colofs_r <= cfg_pwdata[15:0];
        REG_ROW_OFS: rowofs_r <= cfg_pwdata[15:0];
        REG_BPR:     bpr_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:   cfg_prdata = {28'd0, width_r};
      REG_HEIGHT:  cfg_prdata = {28'd0, height_r};
      REG_FORMAT:  cfg_prdata = {31'd0, format_r};
      REG_COL_OFS: cfg_prdata = {16'd0, colofs_r};
      REG_ROW_OFS: cfg_prdata = {16'd0, rowofs_r};
      REG_BPR:     cfg_prdata = {16'd0, bpr_r};
      default:     cfg_prdata = '0;
    endcase
  end

  dtps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .out_valid,
    .sts, .cmd
  );

  dtps_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_opcode, .in_pos_x, .in_pos_y, .in_depth, .in_red, .in_green,
    .in_blue, .in_alpha, .in_rect_left, .in_rect_top, .in_rect_right,
    .in_rect_bottom,
    .width_in_use(width_r), .height_in_use(height_r), .pixel_format(format_r),
    .column_offset(colofs_r), .row_offset(rowofs_r), .bytes_per_row(bpr_r),
    .out_write_enable, .out_byte_address, .out_write_data, .out_four_bytes,
    .out_last
  );
endmodule

>>> dv/tb_depth_tested_pixel_store_flush.sv
// Self-checking testbench for the depth-tested pixel store with touched-list flush.
`timescale 1ns / 1ps
module tb_depth_tested_pixel_store_flush import dtps_pkg::*; ();

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] pos_x, pos_y;
    logic [31:0] depth;
    logic [7:0]  red, green, blue, alpha;
    logic [15:0] rect_left, rect_top, rect_right, rect_bottom;
  } cmd_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] byte_address;
    logic [31:0] write_data;
    logic        four_bytes;
    logic        last;
  } mem_write_t;

  logic clk, rst_n;
  logic in_valid = 0;
  logic in_ready;
  cmd_t cur = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_write_enable, out_four_bytes, out_last;
  logic [31:0] out_byte_address, out_write_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  depth_tested_pixel_store_flush dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(cur.opcode), .in_pos_x(cur.pos_x), .in_pos_y(cur.pos_y),
    .in_depth(cur.depth), .in_red(cur.red), .in_green(cur.green),
    .in_blue(cur.blue), .in_alpha(cur.alpha),
    .in_rect_left(cur.rect_left), .in_rect_top(cur.rect_top),
    .in_rect_right(cur.rect_right), .in_rect_bottom(cur.rect_bottom),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_write_enable(out_write_enable), .out_byte_address(out_byte_address),
    .out_write_data(out_write_data), .out_four_bytes(out_four_bytes),
    .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow of the block's state and registers.
  logic [3:0]  width_reg, height_reg;
  logic        format_reg;
  logic [15:0] col_ofs_reg, row_ofs_reg, bpr_reg;
  logic [31:0] depth_mem [Pixels];
  logic [31:0] color_mem [Pixels];
  logic        visited [Pixels];
  logic        listed [Pixels];
  int          touched [Pixels];
  int          touched_cnt;

  cmd_t       pending_cmds[$];
  mem_write_t expected_writes[$];
  int errors = 0;
  int cycles = 0;
  logic no_idle = 0;
  int in_gap = 0, out_gap = 0;
  logic in_ready_seen = 0;
  logic drive_en = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("** depth_tested_pixel_store_flush: FAILED **");
      $finish;
    end
  end

  function automatic logic pixel_at(input logic [15:0] fx, input logic [15:0] fy,
                                    output int idx);
    int w, h;
    w = width_reg < MaxWidth ? width_reg : MaxWidth;
    h = height_reg < MaxHeight ? height_reg : MaxHeight;
    if ($signed(fx) < 0 || $signed(fy) < 0) return 0;
    if (int'(fx) >= w || int'(fy) >= h) return 0;
    idx = int'(fy) * MaxWidth + int'(fx);
    return 1;
  endfunction

  task automatic blacken(input int p);
    depth_mem[p] = 0;
    color_mem[p] = 0;
    visited[p] = 0;
  endtask

  task automatic queue_cmd(input cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic add_write(input mem_write_t w);
    expected_writes = {expected_writes, w};
  endtask

  // Updates the shadow state and queues the memory writes an item causes.
  task automatic predict_pixel_writes(input cmd_t c);
    int idx, p, x, y;
    logic in_rect, have;
    logic [31:0] col;
    mem_write_t w, held;
    have = 0;
    held = '0;
    case (c.opcode)
      OP_SET: begin
        col = {c.alpha, c.red, c.green, c.blue};
        if (pixel_at(c.pos_x, c.pos_y, idx)) begin
          if (!visited[idx]) begin
            depth_mem[idx] = c.depth;
            color_mem[idx] = col;
            visited[idx] = 1;
            if (!listed[idx] && touched_cnt < Pixels) begin
              listed[idx] = 1;
              touched[touched_cnt] = idx;
              touched_cnt++;
            end
          end else if ($signed(c.depth) < $signed(depth_mem[idx])) begin
            depth_mem[idx] = c.depth;
            color_mem[idx] = col;
          end
        end
      end
      OP_FLUSH_ALL, OP_FLUSH_OUT, OP_FLUSH_IN: begin
        for (int i = 0; i < touched_cnt; i++) begin
          p = touched[i];
          x = p % MaxWidth;
          y = p / MaxWidth;
          in_rect = $signed(c.rect_left) <= x && x <= $signed(c.rect_right) &&
                    $signed(c.rect_top) <= y && y <= $signed(c.rect_bottom);
          if (c.opcode == OP_FLUSH_OUT && in_rect) continue;
          if (c.opcode == OP_FLUSH_IN && !in_rect) continue;
          w.write_enable = 1;
          w.byte_address = (32'(x) + col_ofs_reg) * (format_reg ? 32'd2 : 32'd4) +
                           (32'(y) + row_ofs_reg) * bpr_reg;
          if (format_reg)
            w.write_data = {16'd0, color_mem[p][23:19], color_mem[p][15:10],
                            color_mem[p][7:3]};
          else
            w.write_data = color_mem[p];
          w.four_bytes = !format_reg;
          w.last = 0;
          if (have) add_write(held);
          held = w;
          have = 1;
        end
        if (have) begin
          held.last = 1;
          add_write(held);
        end else begin
          w = '0;
          w.last = 1;
          add_write(w);
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < touched_cnt; i++) begin
          blacken(touched[i]);
          listed[touched[i]] = 0;
        end
        touched_cnt = 0;
      end
      OP_CLEAR_PT: if (pixel_at(c.pos_x, c.pos_y, idx)) blacken(idx);
      default: ;
    endcase
  endtask

  // Driver: the prediction is made at acceptance, so it sees the current registers.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_cmds.size() > 0 && drive_en) begin
          cur <= pending_cmds.pop_front();
          in_valid <= 1;
          if (!no_idle && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 14);
        end else begin
          in_valid <= 0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!no_idle && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < Pixels; i++) begin
        blacken(i);
        listed[i] = 0;
        touched[i] = 0;
      end
      touched_cnt = 0;
    end else if (in_valid && in_ready) begin
      predict_pixel_writes(cur);
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  // Monitor.
  always @(posedge clk) begin
    mem_write_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        report("unexpected transfer", out_byte_address, 0);
      end else begin
        e = expected_writes.pop_front();
        if (out_write_enable !== e.write_enable)
          report("write_enable", out_write_enable, e.write_enable);
        if (out_byte_address !== e.byte_address)
          report("byte_address", out_byte_address, e.byte_address);
        if (out_write_data !== e.write_data)
          report("write_data", out_write_data, e.write_data);
        if (out_four_bytes !== e.four_bytes)
          report("four_bytes", out_four_bytes, e.four_bytes);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  task automatic reg_write(input logic [2:0] r, input logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {r, 2'b00}; cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1;
    @(posedge clk);
    case (r)
      REG_WIDTH: width_reg = v[3:0];
      REG_HEIGHT: height_reg = v[3:0];
      REG_FORMAT: format_reg = v[0];
      REG_COL_OFS: col_ofs_reg = v[15:0];
      REG_ROW_OFS: row_ofs_reg = v[15:0];
      default: bpr_reg = v[15:0];
    endcase
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  // Waits for the queued items to be taken and every write to come out.
  task automatic drain();
    drive_en = 1;
    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_writes.size() == 0);
    drive_en = 0;
    repeat (600) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd(input logic [2:0] op);
    cmd_t c;
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = bits[$bits(cmd_t)-1:0];
    c.opcode = op;
    if ($urandom_range(0, 7) != 0) begin
      c.pos_x = 16'($urandom_range(0, 8));
      c.pos_y = 16'($urandom_range(0, 8));
      c.depth = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40) - 20;
    end
    if ($urandom_range(0, 3) != 0) begin
      c.rect_left = 16'($urandom_range(0, 8) - 1);
      c.rect_top = 16'($urandom_range(0, 8) - 1);
      c.rect_right = 16'($urandom_range(0, 8) - 1);
      c.rect_bottom = 16'($urandom_range(0, 8) - 1);
    end
    return c;
  endfunction

  function automatic cmd_t mk(input logic [2:0] op, input int x, input int y,
                              input logic [31:0] z, input logic [31:0] col);
    cmd_t c;
    c = '0;
    c.opcode = op;
    c.pos_x = 16'(x); c.pos_y = 16'(y); c.depth = z;
    {c.alpha, c.red, c.green, c.blue} = col;
    c.rect_left = 1; c.rect_top = 1; c.rect_right = 3; c.rect_bottom = 3;
    return c;
  endfunction

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_cmd(rand_cmd(OP_SET));
      else if (r < 76) queue_cmd(rand_cmd(OP_FLUSH_ALL));
      else if (r < 81) queue_cmd(rand_cmd(OP_FLUSH_OUT));
      else if (r < 86) queue_cmd(rand_cmd(OP_FLUSH_IN));
      else if (r < 89) queue_cmd(rand_cmd(OP_CLEAR_ALL));
      else if (r < 97) queue_cmd(rand_cmd(OP_CLEAR_PT));
      else queue_cmd(rand_cmd(3'($urandom_range(6, 7))));
    end
    drain();
  endtask

  initial begin
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    width_reg = 8; height_reg = 8; format_reg = 0;
    col_ofs_reg = 0; row_ofs_reg = 0; bpr_reg = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: flush of an empty list, extremes, depth test, clear point, unused opcodes, clear all.
    queue_cmd(mk(OP_FLUSH_ALL, 0, 0, 0, 0));
    queue_cmd(mk(OP_SET, 0, 0, 32'h7fffffff, 32'hffffffff));
    queue_cmd(mk(OP_SET, 0, 0, 32'h80000000, 32'h12345678));
    queue_cmd(mk(OP_SET, 0, 0, 32'h7fffffff, 32'h0));
    queue_cmd(mk(OP_SET, 7, 7, 5, 32'h80f8fc08));
    queue_cmd(mk(OP_SET, 8, 0, 5, 32'h1));
    queue_cmd(mk(OP_SET, 16'h8000, 16'h7fff, 5, 32'h1));
    queue_cmd(mk(OP_SET, 2, 2, 9, 32'haabbccdd));
    queue_cmd(mk(OP_CLEAR_PT, 2, 2, 0, 0));
    queue_cmd(mk(OP_FLUSH_IN, 0, 0, 0, 0));
    queue_cmd(mk(OP_SET, 2, 2, 100, 32'h01020304));
    queue_cmd(mk(OP_CLEAR_PT, 16'hffff, 0, 0, 0));
    queue_cmd(mk(OP_FLUSH_OUT, 0, 0, 0, 0));
    queue_cmd(mk(3'd6, 0, 0, 0, 0));
    queue_cmd(mk(3'd7, 0, 0, 0, 0));
    queue_cmd(mk(OP_FLUSH_ALL, 0, 0, 0, 0));
    queue_cmd(mk(OP_CLEAR_ALL, 0, 0, 0, 0));
    queue_cmd(mk(OP_FLUSH_ALL, 0, 0, 0, 0));
    drain();

    random_phase(60);
    reg_write(REG_FORMAT, 1);
    reg_write(REG_COL_OFS, 16'hffff);
    reg_write(REG_ROW_OFS, 16'hffff);
    reg_write(REG_BPR, 16'hffff);
    random_phase(60);
    reg_write(REG_WIDTH, 1);
    reg_write(REG_HEIGHT, 0);
    random_phase(30);
    reg_write(REG_WIDTH, 15);
    reg_write(REG_HEIGHT, 3);
    reg_write(REG_FORMAT, 0);
    reg_write(REG_COL_OFS, 3);
    reg_write(REG_ROW_OFS, 7);
    reg_write(REG_BPR, 40);
    random_phase(80);
    reg_write(REG_WIDTH, 8);
    reg_write(REG_HEIGHT, 8);
    random_phase(60);
    no_idle = 1;
    random_phase(60);

    if (errors == 0) begin
      $display("** depth_tested_pixel_store_flush: PASSED **");
    end else begin
      $display("** depth_tested_pixel_store_flush: FAILED **");
    end
    $finish;
  end
endmodule
